// ===== src/obb_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_pkg
// Widths, stage enables and the quarter-wave sine table used by the oriented
// box overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package obb_pkg;

   localparam int COORD_BITS     = 16;
   localparam int ANGLE_BITS     = 12;
   localparam int TRIG_FRAC_BITS = 15;

   localparam int SIZE_BITS    = COORD_BITS - 1;
   localparam int QUARTER      = 1 << (ANGLE_BITS - 2);
   localparam int RDX_BITS     = ANGLE_BITS - 2;
   localparam int ADDR_BITS    = ANGLE_BITS - 1;
   localparam int SIN_BITS     = TRIG_FRAC_BITS + 1;
   localparam int TRIG_BITS    = TRIG_FRAC_BITS + 2;
   localparam int CENTER2_BITS = COORD_BITS + TRIG_FRAC_BITS + 1;
   localparam int EXT_BITS     = TRIG_BITS + SIZE_BITS + 1;
   localparam int CORNER_BITS  = COORD_BITS + TRIG_FRAC_BITS + 4;
   localparam int PROD_BITS    = CORNER_BITS + TRIG_BITS;
   localparam int DOT_BITS     = PROD_BITS + 1;
   localparam int NUM_AXES     = 4;
   localparam int NUM_CORNERS  = 4;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

   typedef logic signed [TRIG_BITS-1:0]   trig_type;
   typedef logic signed [CORNER_BITS-1:0] corner_type;
   typedef logic signed [DOT_BITS-1:0]    dot_type;
   typedef logic [SIN_BITS-1:0]           sin_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef sin_type sin_table_type [QUARTER+1];

   typedef struct packed {
      logic rom;
      logic frame;
      logic corner;
      logic product;
      logic dot;
      logic bound;
      logic result;
   } stage_en_type;

   function automatic logic [63:0] mulq62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // shift and subtract quotient, table build only
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sin_type quarter_sin(input int steps);
      logic [127:0] p;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  div;
      p = 128'(steps) * {64'd0, HALF_PI_Q62};
      x = 64'(p >> (ANGLE_BITS - 2));
      x2 = mulq62(x, x);
      term = x;
      sum = x;
      for (int k = 1; k <= 20; k++) begin
         div = 64'((2 * k) * (2 * k + 1));
         term = udiv64(mulq62(term, x2), div);
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      sum = (sum + (64'd1 << (61 - TRIG_FRAC_BITS))) >> (62 - TRIG_FRAC_BITS);
      return sum[SIN_BITS-1:0];
   endfunction

   function automatic sin_table_type build_sin_table();
      sin_table_type t;
      for (int i = 0; i <= QUARTER; i++) begin
         t[i] = quarter_sin(i);
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== src/obb_sin_rom.sv =====
// ----------------------------------------------------------------------------
// obb_sin_rom
// Dual-read quarter-wave sine table, registered read with enable.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_sin_rom (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire obb_pkg::addr_type addr_a,
   input  wire obb_pkg::addr_type addr_b,
   output obb_pkg::sin_type      data_a,
   output obb_pkg::sin_type      data_b
);

   localparam obb_pkg::sin_table_type SinTable = obb_pkg::build_sin_table();

   obb_pkg::sin_type data_a_ff;
   obb_pkg::sin_type data_b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_a_ff <= SinTable[addr_a];
         data_b_ff <= SinTable[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

`default_nettype wire

// ===== src/obb_box_frame.sv =====
// ----------------------------------------------------------------------------
// obb_box_frame
// Builds one box's unit axes, scaled edge vectors and doubled corners.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_box_frame (
   input  wire logic                         clock,
   input  wire obb_pkg::stage_en_type        en,
   input  wire obb_pkg::sin_type             sin0,
   input  wire obb_pkg::sin_type             cos0,
   input  wire logic [1:0]                   quad,
   input  wire logic signed [obb_pkg::COORD_BITS-1:0] center_x,
   input  wire logic signed [obb_pkg::COORD_BITS-1:0] center_y,
   input  wire logic [obb_pkg::SIZE_BITS-1:0] width,
   input  wire logic [obb_pkg::SIZE_BITS-1:0] height,
   output obb_pkg::trig_type                 cos_out,
   output obb_pkg::trig_type                 sin_out,
   output obb_pkg::corner_type               corner_x [obb_pkg::NUM_CORNERS],
   output obb_pkg::corner_type               corner_y [obb_pkg::NUM_CORNERS]
);

   localparam int CB = obb_pkg::CORNER_BITS;
   localparam int EB = obb_pkg::EXT_BITS;

   obb_pkg::trig_type c_in, s_in;
   obb_pkg::trig_type c0_ext, s0_ext;
   logic signed [obb_pkg::SIZE_BITS:0] w_sgn, h_sgn;

   obb_pkg::trig_type c_ff, s_ff, c2_ff, s2_ff;
   logic signed [obb_pkg::EXT_BITS-1:0] ex_ff, ey_ff, fx_ff, fy_ff;
   logic signed [obb_pkg::CENTER2_BITS-1:0] cx2_ff, cy2_ff;
   obb_pkg::corner_type cx_ff [obb_pkg::NUM_CORNERS];
   obb_pkg::corner_type cy_ff [obb_pkg::NUM_CORNERS];

   assign c0_ext = $signed({1'b0, cos0});
   assign s0_ext = $signed({1'b0, sin0});
   assign w_sgn  = $signed({1'b0, width});
   assign h_sgn  = $signed({1'b0, height});

   // quadrant symmetry
   always_comb begin
      case (quad)
         2'd0: begin
            c_in = c0_ext;
            s_in = s0_ext;
         end
         2'd1: begin
            c_in = -s0_ext;
            s_in = c0_ext;
         end
         2'd2: begin
            c_in = -c0_ext;
            s_in = -s0_ext;
         end
         default: begin
            c_in = s0_ext;
            s_in = -c0_ext;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.frame) begin
         c_ff   <= c_in;
         s_ff   <= s_in;
         ex_ff  <= EB'(c_in) * EB'(w_sgn);
         ey_ff  <= EB'(s_in) * EB'(w_sgn);
         fx_ff  <= -(EB'(s_in) * EB'(h_sgn));
         fy_ff  <= EB'(c_in) * EB'(h_sgn);
         cx2_ff <= obb_pkg::CENTER2_BITS'(center_x) <<< (obb_pkg::TRIG_FRAC_BITS + 1);
         cy2_ff <= obb_pkg::CENTER2_BITS'(center_y) <<< (obb_pkg::TRIG_FRAC_BITS + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en.corner) begin
         c2_ff <= c_ff;
         s2_ff <= s_ff;
         for (int i = 0; i < obb_pkg::NUM_CORNERS; i++) begin
            cx_ff[i] <= CB'(cx2_ff)
                      + (((i % 2) == 1) ? CB'(ex_ff) : -CB'(ex_ff))
                      + (((i / 2) == 1) ? CB'(fx_ff) : -CB'(fx_ff));
            cy_ff[i] <= CB'(cy2_ff)
                      + (((i % 2) == 1) ? CB'(ey_ff) : -CB'(ey_ff))
                      + (((i / 2) == 1) ? CB'(fy_ff) : -CB'(fy_ff));
         end
      end
   end

   assign cos_out  = c2_ff;
   assign sin_out  = s2_ff;
   assign corner_x = cx_ff;
   assign corner_y = cy_ff;

endmodule

`default_nettype wire

// ===== src/obb_box_project.sv =====
// ----------------------------------------------------------------------------
// obb_box_project
// Projects one box's corners on all four axes and keeps min and max per axis.
// ----------------------------------------------------------------------------
`default_nettype none

module obb_box_project (
   input  wire logic                  clock,
   input  wire obb_pkg::stage_en_type en,
   input  wire obb_pkg::corner_type   corner_x [obb_pkg::NUM_CORNERS],
   input  wire obb_pkg::corner_type   corner_y [obb_pkg::NUM_CORNERS],
   input  wire obb_pkg::trig_type     axis_x [obb_pkg::NUM_AXES],
   input  wire obb_pkg::trig_type     axis_y [obb_pkg::NUM_AXES],
   output obb_pkg::dot_type           lo [obb_pkg::NUM_AXES],
   output obb_pkg::dot_type           hi [obb_pkg::NUM_AXES]
);

   localparam int NA = obb_pkg::NUM_AXES;
   localparam int NC = obb_pkg::NUM_CORNERS;
   localparam int PB = obb_pkg::PROD_BITS;

   logic signed [obb_pkg::PROD_BITS-1:0] px_ff [NA][NC];
   logic signed [obb_pkg::PROD_BITS-1:0] py_ff [NA][NC];
   obb_pkg::dot_type dot_ff [NA][NC];
   obb_pkg::dot_type lo_ff [NA];
   obb_pkg::dot_type hi_ff [NA];

   obb_pkg::dot_type lo01 [NA], lo23 [NA], hi01 [NA], hi23 [NA];

   always_ff @(posedge clock) begin
      if (en.product) begin
         for (int a = 0; a < NA; a++) begin
            for (int i = 0; i < NC; i++) begin
               px_ff[a][i] <= PB'(corner_x[i]) * PB'(axis_x[a]);
               py_ff[a][i] <= PB'(corner_y[i]) * PB'(axis_y[a]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.dot) begin
         for (int a = 0; a < NA; a++) begin
            for (int i = 0; i < NC; i++) begin
               dot_ff[a][i] <= obb_pkg::DOT_BITS'(px_ff[a][i])
                             + obb_pkg::DOT_BITS'(py_ff[a][i]);
            end
         end
      end
   end

   always_comb begin
      for (int a = 0; a < NA; a++) begin
         lo01[a] = (dot_ff[a][1] < dot_ff[a][0]) ? dot_ff[a][1] : dot_ff[a][0];
         lo23[a] = (dot_ff[a][3] < dot_ff[a][2]) ? dot_ff[a][3] : dot_ff[a][2];
         hi01[a] = (dot_ff[a][1] > dot_ff[a][0]) ? dot_ff[a][1] : dot_ff[a][0];
         hi23[a] = (dot_ff[a][3] > dot_ff[a][2]) ? dot_ff[a][3] : dot_ff[a][2];
      end
   end

   always_ff @(posedge clock) begin
      if (en.bound) begin
         for (int a = 0; a < NA; a++) begin
            lo_ff[a] <= (lo23[a] < lo01[a]) ? lo23[a] : lo01[a];
            hi_ff[a] <= (hi23[a] > hi01[a]) ? hi23[a] : hi01[a];
         end
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

`default_nettype wire

// ===== src/oriented_box_overlap_test.sv =====
// rsp_valid is the valid bit of the last of 7 register stages
// throughput: one request per cycle unless stalled; stages 1..7: sine rom read,
// axis and edge setup, corners, projection products, dot sums, min/max, verdict
// each stage holds only while its successor is full and stalled
// reset clears every stage valid bit; data registers are not reset
// ----------------------------------------------------------------------------
// oriented_box_overlap_test
// Separating axis overlap test of two rotated rectangles, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_box_overlap_test (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic signed [obb_pkg::COORD_BITS-1:0] req_a_center_x,
   input  wire logic signed [obb_pkg::COORD_BITS-1:0] req_a_center_y,
   input  wire logic [obb_pkg::SIZE_BITS-1:0]         req_a_width,
   input  wire logic [obb_pkg::SIZE_BITS-1:0]         req_a_height,
   input  wire logic [obb_pkg::ANGLE_BITS-1:0]        req_a_angle,
   input  wire logic signed [obb_pkg::COORD_BITS-1:0] req_b_center_x,
   input  wire logic signed [obb_pkg::COORD_BITS-1:0] req_b_center_y,
   input  wire logic [obb_pkg::SIZE_BITS-1:0]         req_b_width,
   input  wire logic [obb_pkg::SIZE_BITS-1:0]         req_b_height,
   input  wire logic [obb_pkg::ANGLE_BITS-1:0]        req_b_angle,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic      rsp_collide
);

   localparam int NA = obb_pkg::NUM_AXES;
   localparam int NC = obb_pkg::NUM_CORNERS;
   localparam int RB = obb_pkg::RDX_BITS;
   localparam int AB = obb_pkg::ANGLE_BITS;

   logic [7:1] vld_ff, vld_in;
   logic [7:1] move;
   obb_pkg::stage_en_type en;

   always_comb begin
      move[7] = !vld_ff[7] || rsp_ready;
      for (int k = 6; k >= 1; k--) begin
         move[k] = !vld_ff[k] || move[k+1];
      end
      vld_in[1] = move[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= 7; k++) begin
         vld_in[k] = move[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign en.rom     = move[1];
   assign en.frame   = move[2];
   assign en.corner  = move[3];
   assign en.product = move[4];
   assign en.dot     = move[5];
   assign en.bound   = move[6];
   assign en.result  = move[7];

   // stage 1: sine table lookup and payload capture
   obb_pkg::addr_type a_sin_addr, a_cos_addr, b_sin_addr, b_cos_addr;
   obb_pkg::sin_type  a_sin, a_cos, b_sin, b_cos;

   assign a_sin_addr = obb_pkg::ADDR_BITS'(req_a_angle[RB-1:0]);
   assign a_cos_addr = obb_pkg::ADDR_BITS'(obb_pkg::QUARTER)
                     - obb_pkg::ADDR_BITS'(req_a_angle[RB-1:0]);
   assign b_sin_addr = obb_pkg::ADDR_BITS'(req_b_angle[RB-1:0]);
   assign b_cos_addr = obb_pkg::ADDR_BITS'(obb_pkg::QUARTER)
                     - obb_pkg::ADDR_BITS'(req_b_angle[RB-1:0]);

   obb_sin_rom u_rom_a (
      .clock  (clock),
      .enable (en.rom),
      .addr_a (a_sin_addr),
      .addr_b (a_cos_addr),
      .data_a (a_sin),
      .data_b (a_cos)
   );

   obb_sin_rom u_rom_b (
      .clock  (clock),
      .enable (en.rom),
      .addr_a (b_sin_addr),
      .addr_b (b_cos_addr),
      .data_a (b_sin),
      .data_b (b_cos)
   );

   logic signed [obb_pkg::COORD_BITS-1:0] a_cx_ff, a_cy_ff, b_cx_ff, b_cy_ff;
   logic [obb_pkg::SIZE_BITS-1:0] a_w_ff, a_h_ff, b_w_ff, b_h_ff;
   logic [1:0] a_quad_ff, b_quad_ff;

   always_ff @(posedge clock) begin
      if (en.rom) begin
         a_cx_ff   <= req_a_center_x;
         a_cy_ff   <= req_a_center_y;
         a_w_ff    <= req_a_width;
         a_h_ff    <= req_a_height;
         a_quad_ff <= req_a_angle[AB-1:AB-2];
         b_cx_ff   <= req_b_center_x;
         b_cy_ff   <= req_b_center_y;
         b_w_ff    <= req_b_width;
         b_h_ff    <= req_b_height;
         b_quad_ff <= req_b_angle[AB-1:AB-2];
      end
   end

   // stages 2 and 3: axes, edges, corners
   obb_pkg::trig_type   a_c, a_s, b_c, b_s;
   obb_pkg::corner_type a_px [NC];
   obb_pkg::corner_type a_py [NC];
   obb_pkg::corner_type b_px [NC];
   obb_pkg::corner_type b_py [NC];

   obb_box_frame u_frame_a (
      .clock    (clock),
      .en       (en),
      .sin0     (a_sin),
      .cos0     (a_cos),
      .quad     (a_quad_ff),
      .center_x (a_cx_ff),
      .center_y (a_cy_ff),
      .width    (a_w_ff),
      .height   (a_h_ff),
      .cos_out  (a_c),
      .sin_out  (a_s),
      .corner_x (a_px),
      .corner_y (a_py)
   );

   obb_box_frame u_frame_b (
      .clock    (clock),
      .en       (en),
      .sin0     (b_sin),
      .cos0     (b_cos),
      .quad     (b_quad_ff),
      .center_x (b_cx_ff),
      .center_y (b_cy_ff),
      .width    (b_w_ff),
      .height   (b_h_ff),
      .cos_out  (b_c),
      .sin_out  (b_s),
      .corner_x (b_px),
      .corner_y (b_py)
   );

   obb_pkg::trig_type axis_x [NA];
   obb_pkg::trig_type axis_y [NA];

   assign axis_x[0] = a_c;
   assign axis_y[0] = a_s;
   assign axis_x[1] = -a_s;
   assign axis_y[1] = a_c;
   assign axis_x[2] = b_c;
   assign axis_y[2] = b_s;
   assign axis_x[3] = -b_s;
   assign axis_y[3] = b_c;

   // stages 4 to 6: projections and intervals
   obb_pkg::dot_type a_lo [NA];
   obb_pkg::dot_type a_hi [NA];
   obb_pkg::dot_type b_lo [NA];
   obb_pkg::dot_type b_hi [NA];

   obb_box_project u_proj_a (
      .clock    (clock),
      .en       (en),
      .corner_x (a_px),
      .corner_y (a_py),
      .axis_x   (axis_x),
      .axis_y   (axis_y),
      .lo       (a_lo),
      .hi       (a_hi)
   );

   obb_box_project u_proj_b (
      .clock    (clock),
      .en       (en),
      .corner_x (b_px),
      .corner_y (b_py),
      .axis_x   (axis_x),
      .axis_y   (axis_y),
      .lo       (b_lo),
      .hi       (b_hi)
   );

   // stage 7: verdict
   logic separated;
   logic collide_ff;

   always_comb begin
      separated = 1'b0;
      for (int a = 0; a < NA; a++) begin
         if ((a_hi[a] < b_lo[a]) || (b_hi[a] < a_lo[a])) begin
            separated = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.result) begin
         collide_ff <= !separated;
      end
   end

   assign req_ready   = move[1];
   assign rsp_valid   = vld_ff[7];
   assign rsp_collide = collide_ff;

   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[1] |-> req_ready)
      else $error("input stalled with empty first stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[1])
      else $error("accepted request did not enter the pipeline");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && vld_ff[6] |=> vld_ff[6] && rsp_valid)
      else $error("stalled stage lost its request");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[6] && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("response without a request");

endmodule

`default_nettype wire
